@@ design/hcb_pkg.sv @@
// Shared constants, codes and record types of the Huffman codebook builder.
package hcb_pkg;

    // Alphabet, count and code length limits
    localparam int SYMBOLS      = 257;
    localparam int COUNT_BITS   = 24;
    localparam int MAX_CODE_LEN = 48;

    // Derived sizes
    localparam int NODES      = 2 * SYMBOLS - 1;
    localparam int END_SYM    = SYMBOLS - 1;
    localparam int SYM_BITS   = $clog2(SYMBOLS);
    localparam int NUM_BITS   = $clog2(SYMBOLS + 1);
    localparam int NODE_BITS  = $clog2(NODES);
    localparam int NCNT_BITS  = COUNT_BITS + SYM_BITS;
    localparam int DEPTH_BITS = $clog2(SYMBOLS);
    localparam int LEN_BITS   = $clog2(MAX_CODE_LEN + 1);

    // Fixed port field widths
    localparam int IN_SYM_W  = 9;
    localparam int OUT_LEN_W = 6;
    localparam int OUT_CW_W  = 48;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_BUILD = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LONG  = 2'd1,
        STAT_NOT_BUILT = 2'd2
    } t_status;

    // Ranked list entry: node weight and node id
    typedef struct packed {
        logic [NCNT_BITS-1:0] cnt;
        logic [NODE_BITS-1:0] id;
    } t_rank;

    // Children of an inner node
    typedef struct packed {
        logic [NODE_BITS-1:0] c1;
        logic [NODE_BITS-1:0] c0;
    } t_child;

    // Depth and root-first path bits of a node
    typedef struct packed {
        logic [DEPTH_BITS-1:0]   depth;
        logic [MAX_CODE_LEN-1:0] bits;
    } t_path;

    // Codebook entry of one symbol
    typedef struct packed {
        logic                    present;
        logic                    too_long;
        logic [LEN_BITS-1:0]     len;
        logic [MAX_CODE_LEN-1:0] bits;
    } t_code;

endpackage

@@ design/huffman_codebook_builder_unit.sv @@
// Huffman codebook builder: byte frequency counter, tree builder and codebook reader.
//
// Count and read transactions are taken one per clock cycle, back to back, while
// the unit is idle and no read result is stalled; a count is a read-modify-write
// of the frequency memory with forwarding, and a read presents its result through
// the codebook memory read register, then the output register. One further read is
// taken while an earlier result waits, after which the input holds until the
// output moves. A build stalls the input until done: a frequency scan of all
// symbols, an insertion of each used symbol into the ranked list that shifts
// lighter entries down one list position at a time, leaf relabelling, merges,
// path assignment for each inner node, and writing the codebook; the registered
// read of the ranked list memory sets the pace of the insertion walk.
module huffman_codebook_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [8:0] symbol
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [0] present, [6:1] code_length, [54:7] codeword
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    typedef enum logic [4:0] {
        ST_IDLE, SRT_FETCH, SRT_GOT, INS_RD, INS_CMP, REL_RD, REL_WR,
        MRG_RD_A, MRG_RD_B, MRG_SUM, PTH_INIT, PTH_RD, PTH_W1, PTH_W0,
        CT_CLR, CT_RD, CT_WR
    } t_state;

    localparam logic [hcb_pkg::COUNT_BITS-1:0] CNT_MAX = {hcb_pkg::COUNT_BITS{1'b1}};

    // Memories
    logic [hcb_pkg::COUNT_BITS-1:0] cnt_mem  [hcb_pkg::SYMBOLS];
    logic [hcb_pkg::SYM_BITS-1:0]   leaf_mem [hcb_pkg::SYMBOLS];
    hcb_pkg::t_rank                 rank_mem [hcb_pkg::SYMBOLS];
    hcb_pkg::t_child                child_mem[hcb_pkg::NODES];
    hcb_pkg::t_path                 path_mem [hcb_pkg::NODES];
    hcb_pkg::t_code                 code_mem [hcb_pkg::SYMBOLS];

    // Control registers
    t_state                          r_state, n_state;
    logic [hcb_pkg::NUM_BITS-1:0]    r_s, n_s;
    logic [hcb_pkg::NUM_BITS-1:0]    r_n, n_n;
    logic [hcb_pkg::SYM_BITS-1:0]    r_j, n_j;
    logic [hcb_pkg::SYM_BITS-1:0]    r_i, n_i;
    logic [hcb_pkg::NODE_BITS-1:0]   r_p, n_p;
    hcb_pkg::t_rank                  r_ins, n_ins;
    logic                            r_ins_sort, n_ins_sort;
    hcb_pkg::t_rank                  r_a, n_a;
    hcb_pkg::t_path                  r_pth, n_pth;
    hcb_pkg::t_child                 r_chd, n_chd;
    logic                            r_built, n_built;
    logic [hcb_pkg::SYMBOLS-1:0]     r_cvalid;

    // Memory read data
    logic [hcb_pkg::COUNT_BITS-1:0]  r_cnt_q;
    logic [hcb_pkg::SYM_BITS-1:0]    r_leaf_q;
    hcb_pkg::t_rank                  r_rank_q;
    hcb_pkg::t_child                 r_child_q;
    hcb_pkg::t_path                  r_path_q;
    hcb_pkg::t_code                  r_code_q;

    // Count pipeline and forwarding
    logic                            r_cv;
    logic [hcb_pkg::SYM_BITS-1:0]    r_csym;
    logic                            r_wv;
    logic [hcb_pkg::SYM_BITS-1:0]    r_wsym;
    logic [hcb_pkg::COUNT_BITS-1:0]  r_wval;
    logic [hcb_pkg::COUNT_BITS-1:0]  cnt_old, cnt_new;

    // Read pipeline and output register
    logic                            r_rd_vld, r_rd_built, r_rd_ok;
    logic                            r_o_vld;
    logic [55:0]                     r_o_data;
    logic [1:0]                      r_o_user;

    // Memory port controls
    logic                            rank_we;
    logic [hcb_pkg::SYM_BITS-1:0]    rank_wa, rank_ra;
    hcb_pkg::t_rank                  rank_wd;
    logic                            leaf_we;
    logic [hcb_pkg::SYM_BITS-1:0]    leaf_wa, leaf_ra;
    logic [hcb_pkg::SYM_BITS-1:0]    leaf_wd;
    logic                            child_we;
    logic [hcb_pkg::NODE_BITS-1:0]   child_wa, child_ra;
    hcb_pkg::t_child                 child_wd;
    logic                            path_we;
    logic [hcb_pkg::NODE_BITS-1:0]   path_wa, path_ra;
    hcb_pkg::t_path                  path_wd;
    logic                            code_we;
    logic [hcb_pkg::SYM_BITS-1:0]    code_wa, code_ra;
    hcb_pkg::t_code                  code_wd;
    logic [hcb_pkg::SYM_BITS-1:0]    cnt_ra;

    logic                            ins_done;
    logic [hcb_pkg::COUNT_BITS-1:0]  sort_cnt;
    hcb_pkg::t_code                  code_mk;

    // Input decode
    logic                            acc;
    hcb_pkg::t_op                    in_op;
    logic [hcb_pkg::IN_SYM_W-1:0]    in_sym;
    logic                            acc_count, acc_read, acc_clear;
    logic                            out_move;

    assign in_op  = hcb_pkg::t_op'(i_s_axis_tuser);
    assign in_sym = i_s_axis_tdata[hcb_pkg::IN_SYM_W-1:0];
    assign o_s_axis_tready = (r_state == ST_IDLE) && !(r_rd_vld && r_o_vld && !i_m_axis_tready);
    assign acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_count = acc && (in_op == hcb_pkg::OP_COUNT)
                       && (32'(in_sym) < 32'(hcb_pkg::END_SYM));
    assign acc_read  = acc && (in_op == hcb_pkg::OP_READ);
    assign acc_clear = acc && (in_op == hcb_pkg::OP_CLEAR);
    assign out_move  = r_rd_vld && (!r_o_vld || i_m_axis_tready);

    // Path of a child from its parent's path
    function automatic hcb_pkg::t_path child_path(hcb_pkg::t_path par, logic b);
        hcb_pkg::t_path res;
        res.depth = par.depth + 1'b1;
        if (32'(res.depth) <= 32'(hcb_pkg::MAX_CODE_LEN)) begin
            res.bits = {par.bits[hcb_pkg::MAX_CODE_LEN-2:0], b};
        end else begin
            res.bits = '0;
        end
        return res;
    endfunction

    // Saturating increment with forwarding of the previous cycle's write
    always_comb begin
        if (r_wv && (r_wsym == r_csym)) begin
            cnt_old = r_wval;
        end else if (r_cvalid[r_csym]) begin
            cnt_old = r_cnt_q;
        end else begin
            cnt_old = '0;
        end
        cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
    end

    assign cnt_ra = (r_state == ST_IDLE) ? hcb_pkg::SYM_BITS'(in_sym)
                                         : r_s[hcb_pkg::SYM_BITS-1:0];

    // Frequency of the scanned symbol; the end symbol always counts once
    always_comb begin
        if (r_s == hcb_pkg::NUM_BITS'(hcb_pkg::END_SYM)) begin
            sort_cnt = hcb_pkg::COUNT_BITS'(1);
        end else if (r_cvalid[r_s[hcb_pkg::SYM_BITS-1:0]]) begin
            sort_cnt = r_cnt_q;
        end else begin
            sort_cnt = '0;
        end
    end

    // Codebook entry of the current leaf
    always_comb begin
        code_mk.present = 1'b1;
        if (32'(r_path_q.depth) > 32'(hcb_pkg::MAX_CODE_LEN)) begin
            code_mk.too_long = 1'b1;
            code_mk.len      = '0;
            code_mk.bits     = '0;
        end else begin
            code_mk.too_long = 1'b0;
            code_mk.len      = hcb_pkg::LEN_BITS'(r_path_q.depth);
            code_mk.bits     = r_path_q.bits;
        end
    end

    // Build sequencer
    always_comb begin
        n_state    = r_state;
        n_s        = r_s;
        n_n        = r_n;
        n_j        = r_j;
        n_i        = r_i;
        n_p        = r_p;
        n_ins      = r_ins;
        n_ins_sort = r_ins_sort;
        n_a        = r_a;
        n_pth      = r_pth;
        n_chd      = r_chd;
        n_built    = r_built;
        rank_we    = 1'b0;
        rank_wa    = r_j;
        rank_wd    = r_ins;
        rank_ra    = r_i;
        leaf_we    = 1'b0;
        leaf_wa    = r_i;
        leaf_wd    = r_rank_q.id[hcb_pkg::SYM_BITS-1:0];
        leaf_ra    = r_i;
        child_we   = 1'b0;
        child_wa   = r_p;
        child_wd   = '{c1: r_rank_q.id, c0: r_a.id};
        child_ra   = r_p;
        path_we    = 1'b0;
        path_wa    = r_p;
        path_wd    = '0;
        path_ra    = r_p;
        code_we    = 1'b0;
        code_wa    = r_s[hcb_pkg::SYM_BITS-1:0];
        code_wd    = '0;
        ins_done   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (acc_clear) begin
                    n_built = 1'b0;
                end
                if (acc && (in_op == hcb_pkg::OP_BUILD)) begin
                    n_s     = '0;
                    n_n     = '0;
                    n_state = SRT_FETCH;
                end
            end
            SRT_FETCH: begin
                n_state = SRT_GOT;
            end
            SRT_GOT: begin
                // insert used symbols into the ranked list, skip unused
                if (sort_cnt != '0) begin
                    n_ins.cnt  = hcb_pkg::NCNT_BITS'(sort_cnt);
                    n_ins.id   = hcb_pkg::NODE_BITS'(r_s);
                    n_j        = r_n[hcb_pkg::SYM_BITS-1:0];
                    n_ins_sort = 1'b1;
                    n_state    = INS_RD;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = SRT_FETCH;
                end
            end
            INS_RD: begin
                if (r_j == '0) begin
                    rank_we  = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    rank_ra = r_j - 1'b1;
                    n_state = INS_CMP;
                end
            end
            INS_CMP: begin
                // shift lighter entries down, else drop the new one in place
                rank_we = 1'b1;
                if (r_rank_q.cnt < r_ins.cnt) begin
                    rank_wd = r_rank_q;
                    n_j     = r_j - 1'b1;
                    n_state = INS_RD;
                end else begin
                    ins_done = 1'b1;
                end
            end
            REL_RD: begin
                n_state = REL_WR;
            end
            REL_WR: begin
                // leaf ids follow rank order
                leaf_we = 1'b1;
                rank_we = 1'b1;
                rank_wa = r_i;
                rank_wd = '{cnt: r_rank_q.cnt, id: hcb_pkg::NODE_BITS'(r_i)};
                if (hcb_pkg::NUM_BITS'(r_i) == r_n - 1'b1) begin
                    n_p = hcb_pkg::NODE_BITS'(r_n);
                    if (r_n == hcb_pkg::NUM_BITS'(1)) begin
                        n_state = PTH_INIT;
                    end else begin
                        n_i     = hcb_pkg::SYM_BITS'(r_n - 1'b1);
                        n_state = MRG_RD_A;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = REL_RD;
                end
            end
            MRG_RD_A: begin
                n_state = MRG_RD_B;
            end
            MRG_RD_B: begin
                rank_ra = r_i - 1'b1;
                n_a     = r_rank_q;
                n_state = MRG_SUM;
            end
            MRG_SUM: begin
                // parent of the two last nodes, then insert it
                child_we   = 1'b1;
                n_ins.cnt  = r_a.cnt + r_rank_q.cnt;
                n_ins.id   = r_p;
                n_j        = r_i - 1'b1;
                n_ins_sort = 1'b0;
                n_p        = r_p + 1'b1;
                n_state    = INS_RD;
            end
            PTH_INIT: begin
                path_we = 1'b1;
                path_wa = r_p - 1'b1;
                n_p     = r_p - 1'b1;
                n_s     = '0;
                n_state = (r_n == hcb_pkg::NUM_BITS'(1)) ? CT_CLR : PTH_RD;
            end
            PTH_RD: begin
                n_state = PTH_W1;
            end
            PTH_W1: begin
                path_we = 1'b1;
                path_wa = r_child_q.c1;
                path_wd = child_path(r_path_q, 1'b1);
                n_pth   = r_path_q;
                n_chd   = r_child_q;
                n_state = PTH_W0;
            end
            PTH_W0: begin
                path_we = 1'b1;
                path_wa = r_chd.c0;
                path_wd = child_path(r_pth, 1'b0);
                if (r_p == hcb_pkg::NODE_BITS'(r_n)) begin
                    n_state = CT_CLR;
                end else begin
                    n_p     = r_p - 1'b1;
                    n_state = PTH_RD;
                end
            end
            CT_CLR: begin
                code_we = 1'b1;
                if (r_s == hcb_pkg::NUM_BITS'(hcb_pkg::END_SYM)) begin
                    n_i     = '0;
                    n_state = CT_RD;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            CT_RD: begin
                path_ra = hcb_pkg::NODE_BITS'(r_i);
                n_state = CT_WR;
            end
            CT_WR: begin
                code_we = 1'b1;
                code_wa = r_leaf_q;
                code_wd = code_mk;
                if (hcb_pkg::NUM_BITS'(r_i) == r_n - 1'b1) begin
                    n_built = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = CT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Return from an insertion walk
        if (ins_done) begin
            if (r_ins_sort) begin
                n_n = r_n + 1'b1;
                if (r_s == hcb_pkg::NUM_BITS'(hcb_pkg::END_SYM)) begin
                    n_i     = '0;
                    n_state = REL_RD;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = SRT_FETCH;
                end
            end else if (r_i == hcb_pkg::SYM_BITS'(1)) begin
                n_state = PTH_INIT;
            end else begin
                n_i     = r_i - 1'b1;
                n_state = MRG_RD_A;
            end
        end
    end

    assign code_ra = hcb_pkg::SYM_BITS'(in_sym);

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (r_cv) begin
            cnt_mem[r_csym] <= cnt_new;
        end
        r_cnt_q <= cnt_mem[cnt_ra];
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        r_rank_q <= rank_mem[rank_ra];
        if (leaf_we) begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        r_leaf_q <= leaf_mem[leaf_ra];
        if (child_we) begin
            child_mem[child_wa] <= child_wd;
        end
        r_child_q <= child_mem[child_ra];
        if (path_we) begin
            path_mem[path_wa] <= path_wd;
        end
        r_path_q <= path_mem[path_ra];
        if (code_we) begin
            code_mem[code_wa] <= code_wd;
        end
        if (acc_read) begin
            r_code_q <= code_mem[code_ra];
        end
    end

    // State, pipelines and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_built  <= 1'b0;
            r_cvalid <= '0;
            r_cv     <= 1'b0;
            r_wv     <= 1'b0;
            r_rd_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;

            // count pipeline; a clear wins over the write in flight
            r_cv <= acc_count;
            r_wv <= r_cv;
            if (acc_clear) begin
                r_cvalid <= '0;
            end else if (r_cv) begin
                r_cvalid[r_csym] <= 1'b1;
            end

            // read pipeline
            if (acc_read) begin
                r_rd_vld <= 1'b1;
            end else if (out_move) begin
                r_rd_vld <= 1'b0;
            end
            if (out_move) begin
                r_o_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end

        // payload registers
        r_s        <= n_s;
        r_n        <= n_n;
        r_j        <= n_j;
        r_i        <= n_i;
        r_p        <= n_p;
        r_ins      <= n_ins;
        r_ins_sort <= n_ins_sort;
        r_a        <= n_a;
        r_pth      <= n_pth;
        r_chd      <= n_chd;
        r_csym     <= hcb_pkg::SYM_BITS'(in_sym);
        r_wsym     <= r_csym;
        r_wval     <= cnt_new;
        if (acc_read) begin
            r_rd_built <= r_built;
            r_rd_ok    <= 32'(in_sym) < 32'(hcb_pkg::SYMBOLS);
        end
        if (out_move) begin
            if (!r_rd_built) begin
                r_o_data <= '0;
                r_o_user <= hcb_pkg::STAT_NOT_BUILT;
            end else if (r_rd_ok && r_code_q.present) begin
                r_o_data <= {1'b0, hcb_pkg::OUT_CW_W'(r_code_q.bits),
                             hcb_pkg::OUT_LEN_W'(r_code_q.len), 1'b1};
                r_o_user <= r_code_q.too_long ? hcb_pkg::STAT_TOO_LONG : hcb_pkg::STAT_OK;
            end else begin
                r_o_data <= '0;
                r_o_user <= hcb_pkg::STAT_OK;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;

    // A stalled read result blocks every new transaction
    a_read_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && r_o_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("transaction taken while read result stalled");

    // A counted entry never wraps to zero
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (cnt_new != '0))
        else $error("frequency wrapped");

    // Merge insertion stays above the merged pair's slot
    a_merge_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == INS_RD) && !r_ins_sort) |-> (r_j < r_i))
        else $error("merge insertion out of range");

    // The codebook becomes valid only at the end of a build
    a_built_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_built) |-> ($past(r_state) == CT_WR))
        else $error("built flag set outside codebook write");

    // Leaf count stays within the alphabet
    a_leaf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (32'(r_n) <= 32'(hcb_pkg::SYMBOLS)))
        else $error("leaf count beyond alphabet");

endmodule
